>>> design/tlpil_pkg.sv
// Package for the two-level partitioned index list core.
// Holds field widths, opcodes, default parameter values and the
// controller/datapath command and status types. No dependencies.
`default_nettype none

package tlpil_pkg;

    // Fixed port field widths
    localparam int OP_W      = 3;
    localparam int POS_W     = 10;
    localparam int IN_VAL_W  = 16;
    localparam int OUT_VAL_W = 16;
    localparam int OUT_CNT_W = 11;

    // Default configuration
    localparam int DEF_MAX_ENTRIES = 1024;
    localparam int DEF_VALUE_BITS  = 16;

    // Operation codes
    localparam logic [OP_W-1:0] OP_APPEND     = 3'd0;
    localparam logic [OP_W-1:0] OP_INTO_INNER = 3'd1;
    localparam logic [OP_W-1:0] OP_INTO_OUTER = 3'd2;
    localparam logic [OP_W-1:0] OP_OUT_INNER  = 3'd3;
    localparam logic [OP_W-1:0] OP_OUT_OUTER  = 3'd4;
    localparam logic [OP_W-1:0] OP_READ       = 3'd5;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;    // capture the accepted input transfer
        logic eval;       // decode, commit counters, issue memory reads/append
        logic wr_first;   // write partner data at the position
        logic wr_second;  // write position data at the partner
        logic load_out;   // load the result register
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic do_swap;    // evaluated operation needs a swap
        logic out_hold;   // result register still occupied
    } dp_sts_t;

endpackage

`default_nettype wire

>>> design/tlpil_ctrl.sv
// Controller state machine for the two-level partitioned index list.
// Sequences accept, evaluate, two-step swap write and result load.
// Depends on tlpil_pkg.
`default_nettype none

module tlpil_ctrl
    import tlpil_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire dp_sts_t sts,
    output dp_cmd_t      cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_EVAL = 5'b00010,
        ST_WR1  = 5'b00100,
        ST_WR2  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load_in = in_valid;
                if (in_valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = sts.do_swap ? ST_WR1 : ST_DONE;
            end
            ST_WR1:
            begin
                cmd.wr_first = 1'b1;
                state_next   = ST_WR2;
            end
            ST_WR2:
            begin
                cmd.wr_second = 1'b1;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                if (!sts.out_hold)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready = (state_reg == ST_IDLE);

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> design/tlpil_dp.sv
// Datapath for the two-level partitioned index list: input capture,
// boundary counters, entry memory (two read ports, one write port) and
// the result register. Depends on tlpil_pkg.
`default_nettype none

module tlpil_dp
    import tlpil_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int VALUE_BITS  = DEF_VALUE_BITS
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire dp_cmd_t              cmd,
    output dp_sts_t                   sts,
    input  wire logic [OP_W-1:0]      opcode,
    input  wire logic [POS_W-1:0]     position,
    input  wire logic [IN_VAL_W-1:0]  entry_value,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [OUT_VAL_W-1:0]      read_value,
    output logic [OUT_CNT_W-1:0]      inner_end,
    output logic [OUT_CNT_W-1:0]      outer_end,
    output logic [OUT_CNT_W-1:0]      length,
    output logic                      swapped,
    output logic                      error
);

    localparam int ADDR_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_ENTRIES);
    localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);

    // Captured input
    logic [OP_W-1:0]       op_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [VALUE_BITS-1:0] val_reg;

    // Boundary counters
    logic [CNT_W-1:0] inner_reg, outer_reg, list_reg;
    logic [CNT_W-1:0] inner_next, outer_next, list_next;

    // Decisions kept from the evaluate cycle
    logic [ADDR_W-1:0] partner_reg, partner_next;
    logic              sw_reg, sw_next;
    logic              err_reg, err_next;
    logic              rdf_reg, rdf_next;
    logic              swap_next, app_next;

    // Memory
    logic [VALUE_BITS-1:0] mem [MAX_ENTRIES];
    logic [VALUE_BITS-1:0] rd_a_reg, rd_b_reg;
    logic [ADDR_W-1:0]     wr_addr;
    logic [VALUE_BITS-1:0] wr_data;
    logic                  wr_en;
    logic [ADDR_W-1:0]     pos_addr;

    // Output register
    logic                 out_valid_reg;
    logic [OUT_VAL_W-1:0] rd_out_reg;
    logic [OUT_CNT_W-1:0] inner_out_reg, outer_out_reg, list_out_reg;
    logic                 sw_out_reg, err_out_reg;

    logic [31:0] val_in_ext;
    logic [31:0] rd_a_ext;
    logic [CMP_W-1:0] posx, ix, ox, lx;
    logic pos_bad;

    assign val_in_ext = 32'(entry_value);
    assign rd_a_ext   = 32'(rd_a_reg);
    assign posx       = CMP_W'(pos_reg);
    assign ix         = CMP_W'(inner_reg);
    assign ox         = CMP_W'(outer_reg);
    assign lx         = CMP_W'(list_reg);
    assign pos_bad    = (posx >= lx);
    assign pos_addr   = ADDR_W'(posx);

    // Operation decode and counter update
    always_comb
    begin
        inner_next   = inner_reg;
        outer_next   = outer_reg;
        list_next    = list_reg;
        partner_next = ADDR_W'(ix);
        sw_next      = 1'b0;
        err_next     = 1'b0;
        rdf_next     = 1'b0;
        swap_next    = 1'b0;
        app_next     = 1'b0;
        unique case (op_reg)
            OP_APPEND:
            begin
                if (list_reg == FULL)
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    app_next  = 1'b1;
                    list_next = list_reg + ONE;
                    sw_next   = 1'b1;
                end
            end
            OP_INTO_INNER:
            begin
                if (pos_bad)
                begin
                    err_next = 1'b1;
                end
                else if (!(posx < ix || inner_reg == list_reg))
                begin
                    partner_next = ADDR_W'(ix);
                    inner_next   = inner_reg + ONE;
                    outer_next   = (outer_reg < inner_next) ? inner_next : outer_reg;
                    swap_next    = 1'b1;
                    sw_next      = 1'b1;
                end
            end
            OP_INTO_OUTER:
            begin
                if (pos_bad)
                begin
                    err_next = 1'b1;
                end
                else if (!(posx < ox || outer_reg == list_reg))
                begin
                    partner_next = ADDR_W'(ox);
                    outer_next   = outer_reg + ONE;
                    swap_next    = 1'b1;
                    sw_next      = 1'b1;
                end
            end
            OP_OUT_INNER:
            begin
                if (pos_bad)
                begin
                    err_next = 1'b1;
                end
                else if (posx < ix)
                begin
                    inner_next   = inner_reg - ONE;
                    partner_next = ADDR_W'(inner_next);
                    swap_next    = 1'b1;
                    sw_next      = 1'b1;
                end
            end
            OP_OUT_OUTER:
            begin
                if (pos_bad)
                begin
                    err_next = 1'b1;
                end
                else if (posx < ox)
                begin
                    outer_next   = outer_reg - ONE;
                    partner_next = ADDR_W'(outer_next);
                    inner_next   = (inner_reg > outer_next) ? outer_next : inner_reg;
                    swap_next    = 1'b1;
                    sw_next      = 1'b1;
                end
            end
            OP_READ:
            begin
                if (pos_bad)
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    rdf_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign sts.do_swap  = swap_next;
    assign sts.out_hold = out_valid_reg && !out_ready;

    // Input capture and evaluate-cycle decisions
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg  <= opcode;
            pos_reg <= position;
            val_reg <= val_in_ext[VALUE_BITS-1:0];
        end
        if (cmd.eval)
        begin
            partner_reg <= partner_next;
            sw_reg      <= sw_next;
            err_reg     <= err_next;
            rdf_reg     <= rdf_next;
        end
    end

    // Boundary counters commit in the evaluate cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inner_reg <= '0;
            outer_reg <= '0;
            list_reg  <= '0;
        end
        else if (cmd.eval)
        begin
            inner_reg <= inner_next;
            outer_reg <= outer_next;
            list_reg  <= list_next;
        end
    end

    // Memory write port: append in evaluate, then the two swap halves
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = ADDR_W'(lx);
        wr_data = val_reg;
        if (cmd.eval)
        begin
            wr_en = app_next;
        end
        else if (cmd.wr_first)
        begin
            wr_en   = 1'b1;
            wr_addr = pos_addr;
            wr_data = rd_b_reg;
        end
        else if (cmd.wr_second)
        begin
            wr_en   = 1'b1;
            wr_addr = partner_reg;
            wr_data = rd_a_reg;
        end
    end

    // Entry memory: registered reads at position and partner
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.eval)
        begin
            rd_a_reg <= mem[pos_addr];
            rd_b_reg <= mem[partner_next];
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            rd_out_reg    <= rdf_reg ? rd_a_ext[OUT_VAL_W-1:0] : '0;
            inner_out_reg <= OUT_CNT_W'(inner_reg);
            outer_out_reg <= OUT_CNT_W'(outer_reg);
            list_out_reg  <= OUT_CNT_W'(list_reg);
            sw_out_reg    <= sw_reg;
            err_out_reg   <= err_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = rd_out_reg;
    assign inner_end  = inner_out_reg;
    assign outer_end  = outer_out_reg;
    assign length     = list_out_reg;
    assign swapped    = sw_out_reg;
    assign error      = err_out_reg;

`ifndef SYNTHESIS
    // Boundaries stay nested
    assert property (@(posedge clk) disable iff (!rst_n)
        (inner_reg <= outer_reg) && (outer_reg <= list_reg))
        else $error("boundary nesting broken");

    // List never grows past capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        list_reg <= FULL)
        else $error("list count beyond capacity");

    // A result is never both a change and an error
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> !(sw_out_reg && err_out_reg))
        else $error("result flags swapped and error together");
`endif

endmodule

`default_nettype wire

>>> design/two_level_partitioned_index_list_core.sv
// Two-level partitioned index list core: top level joining controller and datapath.
// Sequence: accept in idle, evaluate, then WR1 and WR2 for a move that swaps, then done,
// which holds while the previous result is unread. A new item is accepted only in idle;
// the swap reads both entries together and writes them back over the single write port.
// Reset (rst_n, async, low): counters zero, no result pending; memory not cleared.
`default_nettype none

module two_level_partitioned_index_list_core
    import tlpil_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int VALUE_BITS  = DEF_VALUE_BITS
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [OP_W-1:0]      opcode,
    input  wire logic [POS_W-1:0]     position,
    input  wire logic [IN_VAL_W-1:0]  entry_value,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [OUT_VAL_W-1:0]      read_value,
    output logic [OUT_CNT_W-1:0]      inner_end,
    output logic [OUT_CNT_W-1:0]      outer_end,
    output logic [OUT_CNT_W-1:0]      length,
    output logic                      swapped,
    output logic                      error
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    // Sequencer
    tlpil_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Counters, memory and result register
    tlpil_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .VALUE_BITS  (VALUE_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .opcode      (opcode),
        .position    (position),
        .entry_value (entry_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_value  (read_value),
        .inner_end   (inner_end),
        .outer_end   (outer_end),
        .length      (length),
        .swapped     (swapped),
        .error       (error)
    );

endmodule

`default_nettype wire

>>> bench/two_level_partitioned_index_list_core_tb.sv
// Self-checking bench for two_level_partitioned_index_list_core: directed table, random
// traffic, a fill to the full list, with random gaps on both valid/ready channels.
// Depends on tlpil_pkg and the core RTL only.
`default_nettype none

module two_level_partitioned_index_list_core_tb;
    import tlpil_pkg::*;

    localparam int LIST_CAP      = DEF_MAX_ENTRIES;
    localparam int RANDOM_ITEMS  = 150;
    localparam int TAIL_ITEMS    = 50;
    localparam int MAX_REPORTS   = 10;
    localparam int LIMIT_CYCLES  = 800000;

    // Spare opcodes, decoded as no-ops
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

    typedef struct packed {
        logic [OUT_VAL_W-1:0] read_value;
        logic [OUT_CNT_W-1:0] inner_end;
        logic [OUT_CNT_W-1:0] outer_end;
        logic [OUT_CNT_W-1:0] length;
        logic                 swapped;
        logic                 error;
    } list_result_t;

    typedef struct {
        logic [OP_W-1:0]     op;
        logic [POS_W-1:0]    pos;
        logic [IN_VAL_W-1:0] val;
        bit                  typed;
        list_result_t        want;
    } list_cmd_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [OP_W-1:0]      opcode = OP_APPEND;
    logic [POS_W-1:0]     position = '0;
    logic [IN_VAL_W-1:0]  entry_value = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [OUT_VAL_W-1:0] read_value;
    logic [OUT_CNT_W-1:0] inner_end;
    logic [OUT_CNT_W-1:0] outer_end;
    logic [OUT_CNT_W-1:0] length;
    logic                 swapped;
    logic                 error;

    two_level_partitioned_index_list_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .position    (position),
        .entry_value (entry_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_value  (read_value),
        .inner_end   (inner_end),
        .outer_end   (outer_end),
        .length      (length),
        .swapped     (swapped),
        .error       (error)
    );

    // Mirror of the list contents and the three boundaries
    logic [IN_VAL_W-1:0] entry_mem [0:LIST_CAP-1];
    int                  inner_cnt = 0;
    int                  outer_cnt = 0;
    int                  list_cnt  = 0;

    list_result_t        pending_list_results [$];
    list_cmd_t           directed_cmds [$];
    list_cmd_t           cur_cmd;
    bit                  calm = 1'b0;
    int                  stall_left = 0;

    int                  fail_count = 0;
    int                  n_sent = 0;
    int                  n_results = 0;
    int                  n_errors = 0;
    int                  n_full_errors = 0;
    int                  n_swaps = 0;
    int                  peak_inner = 0;
    int                  peak_outer = 0;

    // Clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 55)
            return 0;
        else if (k < 85)
            return $urandom_range(1, 3);
        else if (k < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 40);
    endfunction

    function automatic void exchange_entries(int a, int b);
        logic [IN_VAL_W-1:0] t;
        t = entry_mem[a];
        entry_mem[a] = entry_mem[b];
        entry_mem[b] = t;
    endfunction

    // Apply one operation to the mirror and return the result it must produce
    function automatic list_result_t apply_list_op(logic [OP_W-1:0] op,
                                                   logic [POS_W-1:0] pos,
                                                   logic [IN_VAL_W-1:0] val);
        list_result_t r;
        int           p;
        r = '0;
        p = int'(pos);
        if (op == OP_APPEND)
        begin
            if (list_cnt >= LIST_CAP)
                r.error = 1'b1;
            else
            begin
                entry_mem[list_cnt] = val;
                list_cnt++;
                r.swapped = 1'b1;
            end
        end
        else if (op == OP_SPARE_A || op == OP_SPARE_B)
        begin
            // no-op
        end
        else if (p >= list_cnt)
            r.error = 1'b1;
        else
        begin
            case (op)
                OP_INTO_INNER:
                    if (!(p < inner_cnt || inner_cnt == list_cnt))
                    begin
                        exchange_entries(p, inner_cnt);
                        inner_cnt++;
                        if (inner_cnt > outer_cnt)
                            outer_cnt = inner_cnt;
                        r.swapped = 1'b1;
                    end
                OP_INTO_OUTER:
                    if (!(p < outer_cnt || outer_cnt == list_cnt))
                    begin
                        exchange_entries(p, outer_cnt);
                        outer_cnt++;
                        r.swapped = 1'b1;
                    end
                OP_OUT_INNER:
                    if (p < inner_cnt)
                    begin
                        exchange_entries(p, inner_cnt - 1);
                        inner_cnt--;
                        r.swapped = 1'b1;
                    end
                OP_OUT_OUTER:
                    if (p < outer_cnt)
                    begin
                        exchange_entries(p, outer_cnt - 1);
                        outer_cnt--;
                        if (outer_cnt < inner_cnt)
                            inner_cnt = outer_cnt;
                        r.swapped = 1'b1;
                    end
                default:
                    r.read_value = entry_mem[p];
            endcase
        end
        r.inner_end = inner_cnt[OUT_CNT_W-1:0];
        r.outer_end = outer_cnt[OUT_CNT_W-1:0];
        r.length    = list_cnt[OUT_CNT_W-1:0];
        return r;
    endfunction

    // Input side: predict at every accepted transfer
    always @(posedge clk)
    begin
        list_result_t r;
        if (rst_n && in_valid && in_ready)
        begin
            r = apply_list_op(opcode, position, entry_value);
            pending_list_results.insert(pending_list_results.size(),
                                        cur_cmd.typed ? cur_cmd.want : r);
            n_sent++;
            if (inner_cnt > peak_inner)
                peak_inner = inner_cnt;
            if (outer_cnt > peak_outer)
                peak_outer = outer_cnt;
        end
    end

    // Output side: compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        list_result_t got;
        list_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{read_value, inner_end, outer_end, length, swapped, error};
            n_results++;
            if (error)
                n_errors++;
            if (swapped)
                n_swaps++;
            if (pending_list_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected result at %0t: rd=%h in=%0d out=%0d len=%0d sw=%b err=%b",
                             $realtime, read_value, inner_end, outer_end, length, swapped, error);
            end
            else
            begin
                want = pending_list_results.pop_front();
                if (want.error && want.length == LIST_CAP[OUT_CNT_W-1:0])
                    n_full_errors++;
                if (got.read_value !== want.read_value || got.inner_end !== want.inner_end ||
                    got.outer_end !== want.outer_end || got.length !== want.length ||
                    got.swapped !== want.swapped || got.error !== want.error)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                    begin
                        $display("mismatch at %0t (result %0d)", $realtime, n_results);
                        $display("  exp rd=%h in=%0d out=%0d len=%0d sw=%b err=%b",
                                 want.read_value, want.inner_end, want.outer_end,
                                 want.length, want.swapped, want.error);
                        $display("  got rd=%h in=%0d out=%0d len=%0d sw=%b err=%b",
                                 got.read_value, got.inner_end, got.outer_end,
                                 got.length, got.swapped, got.error);
                    end
                end
            end
        end
    end

    // Receiver stalls
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            out_ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 3) == 0)
        begin
            stall_left = pick_gap();
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Present one command after an optional gap; returns at the falling edge after transfer
    task automatic drive_cmd(input list_cmd_t c);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cur_cmd = c;
        in_valid <= 1'b1;
        opcode <= c.op;
        position <= c.pos;
        entry_value <= c.val;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic add_typed(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                             input logic [IN_VAL_W-1:0] val, input logic [OUT_VAL_W-1:0] rd,
                             input int inr, input int outr, input int len,
                             input logic sw, input logic err);
        list_cmd_t c;
        c.op = op;
        c.pos = pos;
        c.val = val;
        c.typed = 1'b1;
        c.want = '{rd, inr[OUT_CNT_W-1:0], outr[OUT_CNT_W-1:0], len[OUT_CNT_W-1:0], sw, err};
        directed_cmds.insert(directed_cmds.size(), c);
    endtask

    task automatic add_checked(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                               input logic [IN_VAL_W-1:0] val);
        list_cmd_t c;
        c.op = op;
        c.pos = pos;
        c.val = val;
        c.typed = 1'b0;
        c.want = '0;
        directed_cmds.insert(directed_cmds.size(), c);
    endtask

    // Random command biased toward in-range positions and the region boundaries
    function automatic list_cmd_t random_cmd(int append_pct);
        list_cmd_t c;
        int        k;
        int        p;
        c.typed = 1'b0;
        c.want = '0;
        k = $urandom_range(0, 99);
        if (k < append_pct)
            c.op = OP_APPEND;
        else
        begin
            k = $urandom_range(0, 99);
            if (k < 20)
                c.op = OP_INTO_INNER;
            else if (k < 40)
                c.op = OP_INTO_OUTER;
            else if (k < 58)
                c.op = OP_OUT_INNER;
            else if (k < 76)
                c.op = OP_OUT_OUTER;
            else if (k < 95)
                c.op = OP_READ;
            else
                c.op = (k < 98) ? OP_SPARE_A : OP_SPARE_B;
        end
        k = $urandom_range(0, 99);
        if (list_cnt == 0 || k < 8)
            p = $urandom_range(0, (1 << POS_W) - 1);
        else if (k < 25)
        begin
            case ($urandom_range(0, 5))
                0: p = inner_cnt;
                1: p = outer_cnt;
                2: p = inner_cnt - 1;
                3: p = outer_cnt - 1;
                4: p = list_cnt - 1;
                default: p = list_cnt;
            endcase
            if (p < 0)
                p = 0;
        end
        else
            p = $urandom_range(0, list_cnt - 1);
        c.pos = p[POS_W-1:0];
        k = $urandom_range(0, 99);
        if (k < 5)
            c.val = '0;
        else if (k < 10)
            c.val = '1;
        else
            c.val = IN_VAL_W'($urandom_range(0, (1 << IN_VAL_W) - 1));
        return c;
    endfunction

    task automatic wait_drained();
        while (pending_list_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Hard stop
    initial
    begin
        #(LIMIT_CYCLES * 12);
        $display("timeout: %0d results still expected", pending_list_results.size());
        $display("FAIL");
        $finish;
    end

    // Stimulus
    initial
    begin
        list_cmd_t c;
        int        i;

        // Empty list: everything but append is out of range; spare opcodes do nothing
        add_typed(OP_READ,       10'd0,    16'h0000, 16'h0000, 0, 0, 0, 1'b0, 1'b1);
        add_typed(OP_INTO_INNER, 10'd0,    16'h0000, 16'h0000, 0, 0, 0, 1'b0, 1'b1);
        add_typed(OP_OUT_OUTER,  10'd1023, 16'hFFFF, 16'h0000, 0, 0, 0, 1'b0, 1'b1);
        add_typed(OP_SPARE_A,    10'd0,    16'h0000, 16'h0000, 0, 0, 0, 1'b0, 1'b0);
        add_typed(OP_SPARE_B,    10'd1023, 16'hFFFF, 16'h0000, 0, 0, 0, 1'b0, 1'b0);
        // Appends of extreme and checkerboard values
        add_typed(OP_APPEND,     10'd1023, 16'h0000, 16'h0000, 0, 0, 1, 1'b1, 1'b0);
        add_typed(OP_APPEND,     10'd0,    16'hFFFF, 16'h0000, 0, 0, 2, 1'b1, 1'b0);
        add_typed(OP_APPEND,     10'd0,    16'hA5A5, 16'h0000, 0, 0, 3, 1'b1, 1'b0);
        add_typed(OP_APPEND,     10'd0,    16'h5A5A, 16'h0000, 0, 0, 4, 1'b1, 1'b0);
        add_typed(OP_READ,       10'd1,    16'h0000, 16'hFFFF, 0, 0, 4, 1'b0, 1'b0);
        add_typed(OP_READ,       10'd1023, 16'h0000, 16'h0000, 0, 0, 4, 1'b0, 1'b1);
        // Moves: inner push raises outer, already-satisfied moves, self swaps
        add_checked(OP_INTO_INNER, 10'd2, 16'h0000);
        add_checked(OP_INTO_INNER, 10'd0, 16'h0000);
        add_checked(OP_INTO_OUTER, 10'd1, 16'h0000);
        add_checked(OP_INTO_OUTER, 10'd3, 16'h0000);
        add_checked(OP_INTO_OUTER, 10'd3, 16'h0000);
        add_checked(OP_INTO_OUTER, 10'd0, 16'h0000);
        add_checked(OP_OUT_INNER,  10'd3, 16'h0000);
        // Shrink outer to zero, dragging inner down with it
        add_checked(OP_OUT_OUTER,  10'd0, 16'h0000);
        add_checked(OP_OUT_OUTER,  10'd0, 16'h0000);
        add_checked(OP_OUT_OUTER,  10'd0, 16'h0000);
        add_checked(OP_OUT_OUTER,  10'd0, 16'h0000);
        add_checked(OP_INTO_INNER, 10'd3, 16'h0000);
        add_checked(OP_OUT_INNER,  10'd0, 16'h0000);
        add_checked(OP_READ,       10'd3, 16'h0000);

        cur_cmd = directed_cmds[0];
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table
        foreach (directed_cmds[j])
            drive_cmd(directed_cmds[j]);

        // Let the pipe empty out before random traffic
        in_valid <= 1'b0;
        wait_drained();

        // Random mix, with quiet stretches free of gaps
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            calm = ((i / 32) % 4) == 3;
            drive_cmd(random_cmd(45));
        end
        calm = 1'b0;

        // Fill the list to capacity with a few moves mixed in, then overrun it
        while (list_cnt < LIST_CAP)
            drive_cmd(random_cmd(95));
        for (i = 0; i < 3; i++)
        begin
            c = random_cmd(100);
            drive_cmd(c);
        end

        in_valid <= 1'b0;
        wait_drained();

        // Full list: moves and reads across the whole position range
        for (i = 0; i < TAIL_ITEMS; i++)
        begin
            calm = i >= TAIL_ITEMS / 2;
            drive_cmd(random_cmd(5));
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (pending_list_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (pending_list_results.size() != 0)
            fail_count++;
        $display("Ran %0d transfers, %0d results checked: %0d errors (%0d on a full list), %0d swaps",
                 n_sent, n_results, n_errors, n_full_errors, n_swaps);
        $display("List reached %0d entries; peak inner %0d, peak outer %0d; %0d failures",
                 list_cnt, peak_inner, peak_outer, fail_count);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

>>> two_level_partitioned_index_list_core.f
design/tlpil_pkg.sv
design/tlpil_ctrl.sv
design/tlpil_dp.sv
design/two_level_partitioned_index_list_core.sv
bench/two_level_partitioned_index_list_core_tb.sv
